### sv/icmh_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed count max-heap core: sizes, heap and map word types,
// and the sequencer state encoding. Depends on nothing.

package icmh_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int COUNT_BITS   = 30;
  localparam int ID_W         = $clog2(NUM_ELEMENTS);
  localparam int SLOT_W       = $clog2(NUM_ELEMENTS);
  localparam int FILL_W       = SLOT_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One heap slot: count in the upper bits, element id below.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [ID_W-1:0]       id;
  } entry_t;

  // One position map word: membership flag and heap slot.
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } map_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int MAP_W   = $bits(map_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC_CHK,
    ST_INC_GET,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_LAST,
    ST_POP_MOV,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_RESP
  } state_e;

endpackage

### sv/icmh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.

module icmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/indexed_count_max_heap_core.sv
`timescale 1ns / 1ps
// Indexed count max-heap: heap RAM of (count, id) words, position map RAM with
// membership flags, and the sift sequencer. Depends on icmh_pkg and icmh_ram.
//
//   channel   direction  signals                                   handshake
//   command   in         op_i, element_id_i                        start, busy
//   result    out        pop_valid_o, popped_element_o,            done_o strobe
//                        popped_count_o, empty_error_o, nonempty_o
//
// An increment checks the map, reads the entry if present and climbs, reading
// and comparing the parent per level. A pop on an empty heap goes straight to
// the response; else it takes the root, moves the last entry up, then descends,
// reading the children and comparing per level. A new word is accepted only in idle.
// The single read port of the heap RAM sets the pace of each level.
// After reset the block clears all 1024 words of the position map, one word a
// cycle, while busy is high. The result strobe lasts one cycle and cannot be
// held off.

module indexed_count_max_heap_core
  import icmh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [ID_W-1:0]       element_id_i,
  output logic                  done_o,
  output logic                  pop_valid_o,
  output logic [ID_W-1:0]       popped_element_o,
  output logic [COUNT_BITS-1:0] popped_count_o,
  output logic                  empty_error_o,
  output logic                  nonempty_o
);

  state_e state_q, state_d;

  logic [ID_W-1:0]       id_q, id_d;
  entry_t                cur_q, cur_d;
  entry_t                left_q, left_d;
  logic [SLOT_W-1:0]     pos_q, pos_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;
  logic                  pv_q, pv_d;
  logic [ID_W-1:0]       pe_q, pe_d;
  logic [COUNT_BITS-1:0] pc_q, pc_d;
  logic                  err_q, err_d;

  // Memory ports.
  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr;
  entry_t            heap_wdata, heap_rdata;
  logic              map_we;
  logic [ID_W-1:0]   map_waddr, map_raddr;
  map_t              map_wdata, map_rdata;

  // Address arithmetic for the walk.
  logic [SLOT_W-1:0] parent;
  logic [SLOT_W+1:0] left_slot, right_slot, fill_ext;
  logic              left_in, right_in;
  logic [FILL_W-1:0] fill_dec;
  entry_t            pick;
  logic              pick_right;
  logic              accept;

  assign accept     = start && !busy;
  assign parent     = (pos_q - SLOT_W'(1)) >> 1;
  assign left_slot  = {1'b0, pos_q, 1'b1};
  assign right_slot = left_slot + (SLOT_W+2)'(1);
  assign fill_ext   = (SLOT_W+2)'(fill_q);
  assign left_in    = left_slot < fill_ext;
  assign right_in   = right_slot < fill_ext;
  assign fill_dec   = fill_q - FILL_W'(1);
  assign pick_right = right_in && (left_q.count < heap_rdata.count);
  assign pick       = pick_right ? heap_rdata : left_q;

  icmh_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_ELEMENTS)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  icmh_ram #(.WIDTH(MAP_W), .DEPTH(NUM_ELEMENTS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == SLOT_W'(NUM_ELEMENTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!op_i) state_d = ST_INC_CHK;
          else if (fill_q == '0) state_d = ST_RESP;
          else state_d = ST_POP_LAST;
        end
      end
      ST_INC_CHK: begin
        if (map_rdata.present) state_d = ST_INC_GET;
        else if (fill_q < FILL_W'(NUM_ELEMENTS)) state_d = ST_UP_RD;
        else state_d = ST_RESP;
      end
      ST_INC_GET: state_d = ST_UP_RD;
      ST_UP_RD: begin
        state_d = (pos_q == '0) ? ST_RESP : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_d = (cur_q.count > heap_rdata.count) ? ST_UP_RD : ST_RESP;
      end
      ST_POP_LAST: begin
        state_d = (fill_dec == '0) ? ST_RESP : ST_POP_MOV;
      end
      ST_POP_MOV: state_d = ST_DN_RDL;
      ST_DN_RDL: begin
        state_d = left_in ? ST_DN_RDR : ST_RESP;
      end
      ST_DN_RDR: state_d = ST_DN_CMP;
      ST_DN_CMP: begin
        state_d = (cur_q.count < pick.count) ? ST_DN_RDL : ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    id_d       = id_q;
    cur_d      = cur_q;
    left_d     = left_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    clr_d      = clr_q;
    pv_d       = pv_q;
    pe_d       = pe_q;
    pc_d       = pc_q;
    err_d      = err_q;
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = cur_q;
    heap_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = cur_q.id;
    map_wdata  = '{present: 1'b1, slot: pos_q};
    map_raddr  = element_id_i;
    unique case (state_q)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = '0;
        clr_d     = clr_q + SLOT_W'(1);
      end
      ST_IDLE: begin
        // The root and the map word are read ahead on every idle cycle.
        if (accept) begin
          id_d  = element_id_i;
          pv_d  = 1'b0;
          pe_d  = '0;
          pc_d  = '0;
          err_d = op_i && (fill_q == '0);
        end
      end
      ST_INC_CHK: begin
        if (map_rdata.present) begin
          heap_raddr = map_rdata.slot;
          pos_d      = map_rdata.slot;
        end else if (fill_q < FILL_W'(NUM_ELEMENTS)) begin
          cur_d  = '{count: COUNT_BITS'(1), id: id_q};
          pos_d  = fill_q[SLOT_W-1:0];
          fill_d = fill_q + FILL_W'(1);
        end
      end
      ST_INC_GET: begin
        cur_d = heap_rdata;
        if (heap_rdata.count < COUNT_MAX) cur_d.count = heap_rdata.count + COUNT_BITS'(1);
      end
      ST_UP_RD: begin
        heap_raddr = parent;
        if (pos_q == '0) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      ST_UP_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (cur_q.count > heap_rdata.count) begin
          // Parent moves down into the hole; the climb goes on.
          heap_wdata = heap_rdata;
          map_waddr  = heap_rdata.id;
          pos_d      = parent;
        end
      end
      ST_POP_LAST: begin
        pv_d       = 1'b1;
        pe_d       = heap_rdata.id;
        pc_d       = heap_rdata.count;
        map_we     = 1'b1;
        map_waddr  = heap_rdata.id;
        map_wdata  = '0;
        fill_d     = fill_dec;
        heap_raddr = fill_dec[SLOT_W-1:0];
      end
      ST_POP_MOV: begin
        cur_d = heap_rdata;
        pos_d = '0;
      end
      ST_DN_RDL: begin
        heap_raddr = left_slot[SLOT_W-1:0];
        if (!left_in) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      ST_DN_RDR: begin
        left_d     = heap_rdata;
        heap_raddr = right_slot[SLOT_W-1:0];
      end
      ST_DN_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (cur_q.count < pick.count) begin
          // Larger child moves up into the hole; the descent goes on.
          heap_wdata = pick;
          map_waddr  = pick.id;
          pos_d      = pick_right ? right_slot[SLOT_W-1:0] : left_slot[SLOT_W-1:0];
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      fill_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    cur_q  <= cur_d;
    left_q <= left_d;
    pos_q  <= pos_d;
    pv_q   <= pv_d;
    pe_q   <= pe_d;
    pc_q   <= pc_d;
    err_q  <= err_d;
  end

  // Result word.
  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_RESP);
  assign pop_valid_o      = pv_q;
  assign popped_element_o = pe_q;
  assign popped_count_o   = pc_q;
  assign empty_error_o    = err_q;
  assign nonempty_o       = (fill_q != '0);

endmodule
